FILE: rtl/core/khss_pkg.sv
// Shared types and constants of the key hash shard select block.
// No dependencies; every other file in rtl/core uses it.
`timescale 1ns / 1ps
`default_nettype none
package khss_pkg;

  // Field widths
  localparam int HASH_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int SHARD_CNT_W = 13;
  localparam int SHARD_IDX_W = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int MODE_W      = 2;

  // Shard count saturates here
  localparam int SHARD_LIMIT = 4096;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Remainder bits resolved per cycle in the back part
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = HASH_W / DIV_BITS;

  // Hash start values
  localparam logic [HASH_W-1:0] DJB2_START = 64'd5381;
  localparam logic [HASH_W-1:0] FNV_START  = 64'hcbf29ce484222325;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_MODE   = 2'd0,
    REG_SHARD_COUNT = 2'd1
  } cfg_reg_t;

  // Hash mode codes; any other code hashes as FNV-1a
  typedef enum logic [MODE_W-1:0] {
    MODE_DJB2  = 2'd0,
    MODE_FNV   = 2'd1,
    MODE_ALIAS = 2'd2,
    MODE_SPARE = 2'd3
  } hash_mode_t;

  typedef struct packed {
    hash_mode_t             hash_mode;
    logic [SHARD_CNT_W-1:0] shard_count;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              byte_valid;
    logic              key_last;
  } in_word_t;

  typedef struct packed {
    logic [SHARD_IDX_W-1:0] shard_index;
    logic [HASH_W-1:0]      key_hash;
  } out_word_t;

  // Finished key handed from front to back
  typedef struct packed {
    logic [HASH_W-1:0]      key_hash;
    logic [SHARD_CNT_W-1:0] divisor;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/khss_front.sv
// Front part: unless the queue is full, folds one key byte per cycle into
// the running hash and queues each finished key. Depends on khss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module khss_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  khss_pkg::cfg_t      cfg,
  input  wire                 in_valid,
  output logic                in_stall,
  input  khss_pkg::in_word_t  in_data,
  input  wire                 q_full,
  output logic                q_push,
  output khss_pkg::job_t      q_job
);

  logic [khss_pkg::HASH_W-1:0]      hash_r, hash_nxt;
  logic                             at_start_r, at_start_nxt;
  logic                             accept;
  logic [khss_pkg::HASH_W-1:0]      base;
  logic [khss_pkg::HASH_W-1:0]      byte_ext;
  logic [khss_pkg::HASH_W-1:0]      djb_val;
  logic [khss_pkg::HASH_W-1:0]      fnv_x;
  logic [khss_pkg::HASH_W-1:0]      fnv_val;
  logic [khss_pkg::HASH_W-1:0]      folded;
  logic [khss_pkg::SHARD_CNT_W-1:0] divisor;

  // Hold the input whenever the queue is full
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Pick the start value on the first word of a key
  always_comb begin
    if (at_start_r) begin
      base = (cfg.hash_mode == khss_pkg::MODE_DJB2) ? khss_pkg::DJB2_START
                                                    : khss_pkg::FNV_START;
    end else begin
      base = hash_r;
    end
  end

  // Sign-extend the byte as a signed char
  assign byte_ext = {{(khss_pkg::HASH_W-khss_pkg::BYTE_W){in_data.key_byte[khss_pkg::BYTE_W-1]}},
                     in_data.key_byte};

  // djb2: hash * 33 + byte
  assign djb_val = (base << 5) + base + byte_ext;

  // FNV-1a: (hash ^ byte) * 0x100000001b3, prime split into shifted terms
  assign fnv_x   = base ^ byte_ext;
  assign fnv_val = fnv_x + (fnv_x << 1) + (fnv_x << 4) + (fnv_x << 5)
                 + (fnv_x << 7) + (fnv_x << 8) + (fnv_x << 40);

  always_comb begin
    if (!in_data.byte_valid) begin
      folded = base;
    end else if (cfg.hash_mode == khss_pkg::MODE_DJB2) begin
      folded = djb_val;
    end else begin
      folded = fnv_val;
    end
  end

  // Clamp the shard count to 1..SHARD_LIMIT
  always_comb begin
    if (cfg.shard_count == '0) begin
      divisor = khss_pkg::SHARD_CNT_W'(1);
    end else if (cfg.shard_count > khss_pkg::SHARD_CNT_W'(khss_pkg::SHARD_LIMIT)) begin
      divisor = khss_pkg::SHARD_CNT_W'(khss_pkg::SHARD_LIMIT);
    end else begin
      divisor = cfg.shard_count;
    end
  end

  // Advance the running hash on every accepted word
  always_comb begin
    hash_nxt     = hash_r;
    at_start_nxt = at_start_r;
    if (accept) begin
      hash_nxt     = folded;
      at_start_nxt = in_data.key_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= khss_pkg::DJB2_START;
      at_start_r <= 1'b1;
    end else begin
      hash_r     <= hash_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  // Hand the finished key to the back part
  assign q_push         = accept && in_data.key_last;
  assign q_job.key_hash = folded;
  assign q_job.divisor  = divisor;

endmodule
`default_nettype wire

FILE: rtl/core/khss_queue.sv
// Short queue of finished keys between the front and back parts.
// Depends on khss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module khss_queue #(
  parameter int DEPTH = khss_pkg::QUEUE_DEPTH
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  khss_pkg::job_t  push_job,
  output logic            full,
  input  wire             pop,
  output logic            nonempty,
  output khss_pkg::job_t  pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  khss_pkg::job_t     slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign nonempty = (count_r != '0);
  assign pop_job  = slots_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("khss_queue: push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("khss_queue: pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("khss_queue: count beyond depth");

endmodule
`default_nettype wire

FILE: rtl/core/khss_back.sv
// Back part: reduces each finished hash modulo its shard count, a few
// remainder bits per cycle, and holds the result word. Depends on khss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module khss_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_nonempty,
  input  khss_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output khss_pkg::out_word_t out_data
);

  localparam int CNT_W = (khss_pkg::DIV_CYCLES > 1) ? $clog2(khss_pkg::DIV_CYCLES) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } back_state_t;

  back_state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [khss_pkg::HASH_W-1:0]      quo_r, quo_nxt;
  logic [khss_pkg::HASH_W-1:0]      hash_r, hash_nxt;
  logic [khss_pkg::SHARD_CNT_W-1:0] n_r, n_nxt;
  logic [khss_pkg::SHARD_IDX_W-1:0] rem_r, rem_nxt;
  khss_pkg::out_word_t              out_r, out_nxt;
  logic [khss_pkg::HASH_W-1:0]      quo_v;
  logic [khss_pkg::SHARD_IDX_W-1:0] rem_v;
  logic [khss_pkg::SHARD_CNT_W-1:0] trial;
  logic                             last_step;

  // Restoring remainder steps, most significant bit first
  always_comb begin
    quo_v = quo_r;
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < khss_pkg::DIV_BITS; i++) begin
      trial = {rem_v, quo_v[khss_pkg::HASH_W-1]};
      quo_v = quo_v << 1;
      if (trial >= n_r) begin
        trial = trial - n_r;
      end
      rem_v = trial[khss_pkg::SHARD_IDX_W-1:0];
    end
  end

  assign last_step = (cnt_r == CNT_W'(khss_pkg::DIV_CYCLES - 1));
  assign q_pop     = (state_r == S_IDLE) && q_nonempty;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // Sequence: take a key, iterate the remainder, hold the result
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    hash_nxt  = hash_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    out_nxt   = out_r;
    case (state_r)
      S_IDLE: begin
        if (q_nonempty) begin
          quo_nxt   = q_job.key_hash;
          hash_nxt  = q_job.key_hash;
          n_nxt     = q_job.divisor;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt = quo_v;
        rem_nxt = rem_v;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) begin
          out_nxt.shard_index = rem_v;
          out_nxt.key_hash    = hash_r;
          state_nxt           = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    hash_r <= hash_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
  end

  a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && last_step) |=>
      ({1'b0, out_r.shard_index} < n_r))
    else $error("khss_back: remainder not below shard count");

  a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DIV && cnt_r == '0))
    else $error("khss_back: pop did not start the reduction");

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && last_step) |=> out_valid)
    else $error("khss_back: finished reduction not presented");

endmodule
`default_nettype wire

FILE: rtl/core/key_hash_shard_select_unit.sv
// Path from last key word to result word: queue, load, remainder steps at
// DIV_BITS bits each, output register. One key word per cycle enters the
// front while the queue is not full; the back part takes a new key only
// once its result is taken. The queue absorbs up to QUEUE_DEPTH finished
// keys. Reset (synchronous, rst_n low): hash mode djb2, shard count 1,
// queue empty, next word starts a new key.
`timescale 1ns / 1ps
`default_nettype none
module key_hash_shard_select_unit #(
  parameter int QUEUE_DEPTH = khss_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  khss_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output khss_pkg::out_word_t                out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [khss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [khss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  khss_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_nonempty;
  khss_pkg::job_t push_job;
  khss_pkg::job_t pop_job;

  // Configuration writes always complete
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        khss_pkg::REG_HASH_MODE: begin
          cfg_nxt.hash_mode = khss_pkg::hash_mode_t'(cfg_data[khss_pkg::MODE_W-1:0]);
        end
        khss_pkg::REG_SHARD_COUNT: begin
          cfg_nxt.shard_count = cfg_data[khss_pkg::SHARD_CNT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hash_mode   <= khss_pkg::MODE_DJB2;
      cfg_r.shard_count <= khss_pkg::SHARD_CNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  khss_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  khss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_job  (pop_job)
  );

  khss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for key_hash_shard_select_unit: byte-serial key hashing and shard pick.
// Depends on khss_pkg and the unit itself; a directed script runs first, then randomised phases.
`timescale 1ns / 1ps
module testbench;
  import khss_pkg::*;

  localparam logic [HASH_W-1:0] FNV_MULT = 64'h100000001b3;
  // Register slots with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 94;
  localparam int SCRIPT_LEN = 29;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_word_t               word;
    logic                   typed;
    out_word_t              want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  hash_mode_t cur_mode;
  logic [SHARD_CNT_W-1:0] cur_shards;
  logic [HASH_W-1:0] acc_hash;
  logic fresh_key;

  out_word_t awaited[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Directed script: empty keys and sign extension after reset, every mode,
  // shard count zero and beyond the maximum, a mode switch inside a key,
  // writes to unmapped slots, and keys made only of byteless words
  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'd0, DJB2_START}},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b1, 1'b1}, 1'b1, '{12'd0, 64'd177573}},
    '{ROW_WORD, '0, '0, '{8'hff, 1'b1, 1'b1}, 1'b1, '{12'd0, 64'd177572}},
    '{ROW_WORD, '0, '0, '{8'h80, 1'b1, 1'b1}, 1'b1, '{12'd0, 64'd177445}},
    '{ROW_WORD, '0, '0, '{8'h7f, 1'b1, 1'b1}, 1'b1, '{12'd0, 64'd177700}},
    '{ROW_WORD, '0, '0, '{8'h41, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'hc3, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REG, REG_HASH_MODE, CFG_DATA_W'(MODE_FNV), '0, 1'b0, '0},
    '{ROW_REG, REG_SHARD_COUNT, 13'd4096, '0, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'h325, FNV_START}},
    '{ROW_WORD, '0, '0, '{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h01, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REG, REG_HASH_MODE, CFG_DATA_W'(MODE_ALIAS), '0, 1'b0, '0},
    '{ROW_REG, REG_SHARD_COUNT, 13'd0, '0, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'd0, FNV_START}},
    '{ROW_WORD, '0, '0, '{8'h80, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_REG, REG_HASH_MODE, CFG_DATA_W'(MODE_SPARE), '0, 1'b0, '0},
    '{ROW_REG, REG_SHARD_COUNT, 13'd8191, '0, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'h325, FNV_START}},
    '{ROW_WORD, '0, '0, '{8'h5a, 1'b1, 1'b0}, 1'b0, '0},
    '{ROW_REG, REG_HASH_MODE, CFG_DATA_W'(MODE_DJB2), '0, 1'b0, '0},
    '{ROW_REG, REG_SHARD_COUNT, 13'd4097, '0, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'ha5, 1'b1, 1'b1}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'd1285, DJB2_START}},
    '{ROW_REG, REG_UNMAPPED_LO, 13'd8191, '0, 1'b0, '0},
    '{ROW_REG, REG_UNMAPPED_HI, 13'd0, '0, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{8'h00, 1'b0, 1'b1}, 1'b1, '{12'd1285, DJB2_START}}
  };

  key_hash_shard_select_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Fold one key word into the running hash; return 1 when it closes a key
  function automatic bit hash_key_word(input in_word_t w, output out_word_t res);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] ext;
    logic [HASH_W-1:0] divisor;
    h = fresh_key ? ((cur_mode == MODE_DJB2) ? DJB2_START : FNV_START) : acc_hash;
    if (w.byte_valid) begin
      ext = {{(HASH_W - BYTE_W){w.key_byte[BYTE_W-1]}}, w.key_byte};
      if (cur_mode == MODE_DJB2) begin
        h = h * 64'd33 + ext;
      end else begin
        h = (h ^ ext) * FNV_MULT;
      end
    end
    acc_hash = h;
    fresh_key = w.key_last;
    // Clamp the shard count into 1..SHARD_LIMIT
    if (cur_shards == '0) begin
      divisor = 64'd1;
    end else if (cur_shards > SHARD_LIMIT) begin
      divisor = 64'(SHARD_LIMIT);
    end else begin
      divisor = 64'(cur_shards);
    end
    res.key_hash = h;
    res.shard_index = SHARD_IDX_W'(h % divisor);
    return w.key_last;
  endfunction

  // Offer one key word after a random gap, hold it until taken, then predict
  task automatic send_key_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t res;
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (hash_key_word(w, res)) begin
      if (typed) begin
        res = want;
      end
      awaited = {awaited, res};
    end
  endtask

  // Drop the input, wait for every awaited word, then let the back part go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HASH_MODE: begin
        cur_mode = hash_mode_t'(val[MODE_W-1:0]);
      end
      REG_SHARD_COUNT: begin
        cur_shards = val[SHARD_CNT_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Random stall on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result word with the oldest awaited one
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        flag_mismatch($sformatf("unexpected word shard_index %0d key_hash %h",
                                out_data.shard_index, out_data.key_hash));
      end else begin
        want = awaited.pop_front();
        if (out_data.shard_index != want.shard_index) begin
          flag_mismatch($sformatf("shard_index got %0d want %0d",
                                  out_data.shard_index, want.shard_index));
        end
        if (out_data.key_hash != want.key_hash) begin
          flag_mismatch($sformatf("key_hash got %h want %h", out_data.key_hash, want.key_hash));
        end
      end
    end
  end

  // Give up when no channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    logic [CFG_DATA_W-1:0] mode_val;
    logic [CFG_DATA_W-1:0] count_val;
    int left_in_key;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_mode = MODE_DJB2;
    cur_shards = 13'd1;
    acc_hash = DJB2_START;
    fresh_key = 1'b1;
    left_in_key = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (script[r].kind == ROW_REG) begin
        if (r > 0 && script[r-1].kind == ROW_WORD) begin
          settle_block();
        end
        write_reg(script[r].reg_idx, script[r].reg_val);
      end else begin
        send_key_word(script[r].word, script[r].typed, script[r].want);
      end
    end

    // Random phases: settings from the extremes first, then random ones
    for (int p = 0; p < PHASES; p++) begin
      settle_block();
      case (p)
        0: begin mode_val = CFG_DATA_W'(MODE_DJB2);  count_val = 13'd1;    end
        1: begin mode_val = CFG_DATA_W'(MODE_FNV);   count_val = 13'd4096; end
        2: begin mode_val = CFG_DATA_W'(MODE_ALIAS); count_val = 13'd0;    end
        3: begin mode_val = CFG_DATA_W'(MODE_SPARE); count_val = 13'd8191; end
        4: begin mode_val = CFG_DATA_W'(MODE_DJB2);  count_val = 13'd4097; end
        5: begin
          mode_val = CFG_DATA_W'($urandom_range(8191));
          count_val = CFG_DATA_W'($urandom_range(1, 16));
        end
        6: begin
          mode_val = CFG_DATA_W'($urandom_range(8191));
          count_val = CFG_DATA_W'($urandom_range(8191));
        end
        default: begin
          mode_val = CFG_DATA_W'($urandom_range(8191));
          count_val = CFG_DATA_W'($urandom_range(1, 4096));
        end
      endcase
      write_reg(REG_HASH_MODE, mode_val);
      write_reg(REG_SHARD_COUNT, count_val);
      if (p == 5 || p == 6) begin
        write_reg(($urandom_range(1) != 0) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                  CFG_DATA_W'($urandom_range(8191)));
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase

      // Keys of random length; a phase may end inside a key
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (left_in_key == 0) begin
          left_in_key = ($urandom_range(9) == 0) ? int'($urandom_range(17, 40))
                                                 : int'($urandom_range(1, 8));
        end
        w.byte_valid = ($urandom_range(9) != 0);
        case ($urandom_range(7))
          0: w.key_byte = 8'h00;
          1: w.key_byte = 8'hff;
          2: w.key_byte = 8'h80;
          3: w.key_byte = 8'h7f;
          default: w.key_byte = BYTE_W'($urandom_range(255));
        endcase
        w.key_last = (left_in_key == 1);
        left_in_key--;
        // Cut a key short now and then
        if ($urandom_range(19) == 0) begin
          w.key_last = 1'b1;
          left_in_key = 0;
        end
        send_key_word(w, 1'b0, '0);
      end
    end

    settle_block();
    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
